// ----- design/nggp_pkg.sv -----
// Package for the NMEA GGA/RMC sentence parser.
// Holds character codes, scanner and number-token types, and the per-character
// number-token update functions. No dependencies.
`default_nettype none
package nggp_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam int unsigned FIELD_COUNT = 9;
  localparam int unsigned VAL_W       = 28;
  localparam logic [29:0] INT_CAP     = 30'd1000000000;

  typedef enum logic [1:0] {
    ST_IGNORED = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_GGA     = 2'd2,
    ST_RMC     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_SUM   = 2'd1,
    PH_HEX   = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    TP_BLANK = 2'd0,
    TP_INT   = 2'd1,
    TP_FRAC  = 2'd2,
    TP_END   = 2'd3
  } tok_phase_t;

  typedef struct packed {
    tok_phase_t  phase;
    logic [7:0]  first;
    logic [7:0]  modv;
    logic [2:0]  fdig;
    logic        neg;
    logic [29:0] ival;
    logic [13:0] frac;
    logic [6:0]  frac2;
  } tok_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] xsum;
    logic [7:0] expect_sum;
    logic [1:0] hexn;
    logic [1:0] tmatch;
    logic [3:0] tokn;
    logic       in_tok;
    logic       txt_end;
    tok_t       tok;
  } scan_t;

  typedef struct packed {
    status_t                               status;
    logic [FIELD_COUNT-1:0]                keep;
    logic [FIELD_COUNT-1:0][VAL_W-1:0]     vals;
  } line_end_t;

  function automatic logic [7:0] gga_tag(input logic [2:0] idx);
    case (idx)
      3'd0:    gga_tag = 8'h24;
      3'd1:    gga_tag = 8'h47;
      3'd2:    gga_tag = 8'h50;
      3'd3:    gga_tag = 8'h47;
      3'd4:    gga_tag = 8'h47;
      3'd5:    gga_tag = 8'h41;
      default: gga_tag = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] rmc_tag(input logic [2:0] idx);
    case (idx)
      3'd0:    rmc_tag = 8'h24;
      3'd1:    rmc_tag = 8'h47;
      3'd2:    rmc_tag = 8'h50;
      3'd3:    rmc_tag = 8'h52;
      3'd4:    rmc_tag = 8'h4D;
      3'd5:    rmc_tag = 8'h43;
      default: rmc_tag = 8'h00;
    endcase
  endfunction

  function automatic tok_t tok_feed(input tok_t t, input logic [7:0] c);
    tok_t        r;
    logic        dig;
    logic        skip;
    logic [3:0]  d;
    logic [33:0] prod;
    r    = t;
    dig  = (c >= 8'h30) && (c <= 8'h39);
    d    = c[3:0];
    skip = 1'b0;
    prod = '0;
    if (r.phase == TP_BLANK) begin
      if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
        skip = 1'b1;
      end else begin
        r.phase = TP_INT;
        if (c == CH_PLUS || c == CH_MINUS) begin
          r.neg = (c == CH_MINUS);
          skip  = 1'b1;
        end
      end
    end
    if (!skip && r.phase == TP_INT) begin
      skip = 1'b1;
      if (dig) begin
        if (r.ival < INT_CAP) begin
          prod   = {4'b0, r.ival} * 34'd10 + {30'b0, d};
          r.ival = (prod > {4'b0, INT_CAP}) ? INT_CAP : prod[29:0];
        end
        r.modv = 8'(r.modv * 8'd10 + {4'b0, d});
      end else begin
        r.phase = (c == CH_DOT) ? TP_FRAC : TP_END;
      end
    end
    if (!skip && r.phase == TP_FRAC) begin
      if (dig) begin
        if (r.fdig < 3'd4) begin
          r.frac = 14'(r.frac * 14'd10 + {10'b0, d});
          if (r.fdig < 3'd2) r.frac2 = 7'(r.frac2 * 7'd10 + {3'b0, d});
          r.fdig = r.fdig + 3'd1;
        end
      end else begin
        r.phase = TP_END;
      end
    end
    return r;
  endfunction

  function automatic tok_t tok_begin(input logic [7:0] c);
    tok_t r;
    r       = tok_t'('0);
    r.first = c;
    return tok_feed(r, c);
  endfunction

endpackage
`default_nettype wire

// ----- design/nggp_tok_conv.sv -----
// Converts a finished number token into the fixed-point or character value of its slot.
// Depends on nggp_pkg.
`default_nettype none
module nggp_tok_conv (
  input  nggp_pkg::tok_t     tok,
  input  logic [3:0]         slot,
  output logic [27:0]        value
);
  import nggp_pkg::*;

  logic [13:0] frac4;
  logic [6:0]  frac2s;
  logic [43:0] v4;
  logic [36:0] v2;
  logic [26:0] alt_mag;

  always_comb begin
    case (tok.fdig)
      3'd0:    frac4 = 14'd0;
      3'd1:    frac4 = 14'(tok.frac * 14'd1000);
      3'd2:    frac4 = 14'(tok.frac * 14'd100);
      3'd3:    frac4 = 14'(tok.frac * 14'd10);
      default: frac4 = tok.frac;
    endcase
    case (tok.fdig)
      3'd0:    frac2s = 7'd0;
      3'd1:    frac2s = 7'(tok.frac2 * 7'd10);
      default: frac2s = tok.frac2;
    endcase
  end

  assign v4 = {14'b0, tok.ival} * 44'd10000 + {30'b0, frac4};
  assign v2 = {7'b0, tok.ival} * 37'd100 + {30'b0, frac2s};
  assign alt_mag = (v2 > 37'd100000000) ? 27'd100000000 : v2[26:0];

  always_comb begin
    case (slot)
      4'd0:    value = tok.neg ? 28'd0 : (v2 > 37'h1FFFFFF ? 28'h1FFFFFF : {3'b0, v2[24:0]});
      4'd1:    value = tok.neg ? 28'd0 : (v4 > 44'h7FFFFFF ? 28'h7FFFFFF : {1'b0, v4[26:0]});
      4'd3:    value = tok.neg ? 28'd0 : (v4 > 44'hFFFFFFF ? 28'hFFFFFFF : v4[27:0]);
      4'd2,
      4'd4:    value = {20'b0, tok.first};
      4'd5,
      4'd6:    value = {20'b0, tok.neg ? 8'(8'd0 - tok.modv) : tok.modv};
      4'd7:    value = tok.neg ? 28'd0 : (v2 > 37'hFFFF ? 28'hFFFF : {12'b0, v2[15:0]});
      default: value = tok.neg ? 28'(28'd0 - {1'b0, alt_mag}) : {1'b0, alt_mag};
    endcase
  end

endmodule
`default_nettype wire

// ----- design/nggp_line_scan.sv -----
// Line scanner: framing, tag match, checksum, tokenizing and pending fields.
// A CR is taken at once; the state before it is kept so an LF can undo it.
// Depends on nggp_pkg and nggp_tok_conv.
`default_nettype none
module nggp_line_scan #(
  parameter int unsigned LINE_LIMIT = 127,
  localparam int unsigned LEN_W = $clog2(LINE_LIMIT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  output nggp_pkg::line_end_t line_end
);
  import nggp_pkg::*;

  scan_t            cur, pre, nxt, src;
  logic [LEN_W-1:0] cur_len, pre_len, nxt_len, blen;
  logic             cr_flag;
  logic [VAL_W-1:0] pend [FIELD_COUNT];
  logic [FIELD_COUNT-1:0] pres, pres_eff;
  logic [VAL_W-1:0] pend_eff [FIELD_COUNT];
  logic             is_lf, fin_char, fin, slot_ok;
  logic [3:0]       slot, hexd;
  logic             hex_ok;
  logic [VAL_W-1:0] conv_val;
  logic [1:0]       tm;
  status_t          status;

  assign is_lf = (rx_byte == CH_LF);

  always_comb begin
    hex_ok = 1'b1;
    hexd   = rx_byte[3:0];
    if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
      hexd = rx_byte[3:0];
    end else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) ||
                 (rx_byte >= 8'h61 && rx_byte <= 8'h66)) begin
      hexd = 4'(rx_byte[3:0] + 4'd9);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // One character step of the scanner.
  always_comb begin
    nxt      = cur;
    fin_char = 1'b0;
    nxt_len  = (cur_len < LEN_W'(LINE_LIMIT)) ? cur_len + LEN_W'(1) : cur_len;
    if (!cur.txt_end) begin
      if (rx_byte == CH_NUL) begin
        nxt.txt_end = 1'b1;
        if (cur_len < LEN_W'(6)) nxt.tmatch = 2'b00;
        fin_char   = cur.in_tok;
        nxt.in_tok = 1'b0;
      end else begin
        if (cur_len == '0) begin
          nxt.tmatch = (rx_byte == CH_DOLLAR) ? 2'b11 : 2'b00;
          nxt.phase  = PH_SUM;
        end else begin
          if (cur_len < LEN_W'(6)) begin
            if (rx_byte != gga_tag(cur_len[2:0])) nxt.tmatch[0] = 1'b0;
            if (rx_byte != rmc_tag(cur_len[2:0])) nxt.tmatch[1] = 1'b0;
          end
          if (cur.phase == PH_SUM) begin
            if (rx_byte == CH_STAR) nxt.phase = PH_HEX;
            else nxt.xsum = cur.xsum ^ rx_byte;
          end else if (cur.phase == PH_HEX) begin
            if (!hex_ok) begin
              nxt.phase = PH_DONE;
            end else begin
              nxt.expect_sum = {cur.expect_sum[3:0], hexd};
              nxt.hexn       = cur.hexn + 2'd1;
              if (cur.hexn != 2'd0) nxt.phase = PH_DONE;
            end
          end
        end
        if (rx_byte == CH_COMMA) begin
          fin_char   = cur.in_tok;
          nxt.in_tok = 1'b0;
        end else if (!cur.in_tok) begin
          nxt.in_tok = 1'b1;
          if (cur.tokn != 4'd15) nxt.tokn = cur.tokn + 4'd1;
          nxt.tok = tok_begin(rx_byte);
        end else begin
          nxt.tok = tok_feed(cur.tok, rx_byte);
        end
      end
    end
  end

  assign src  = (is_lf && cr_flag) ? pre : cur;
  assign blen = (is_lf && cr_flag) ? pre_len : cur_len;
  assign fin  = is_lf ? (!src.txt_end && src.in_tok) : fin_char;
  assign slot_ok = (src.tokn >= 4'd2) && (src.tokn <= 4'd10);
  assign slot = src.tokn - 4'd2;

  nggp_tok_conv u_conv (
    .tok   (src.tok),
    .slot  (slot),
    .value (conv_val)
  );

  always_comb begin
    pres_eff = pres;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      pend_eff[i] = pend[i];
      if (fin && slot_ok && slot == 4'(i)) begin
        pend_eff[i] = conv_val;
        pres_eff[i] = 1'b1;
      end
    end
  end

  always_comb begin
    tm     = (blen < LEN_W'(6)) ? 2'b00 : src.tmatch;
    status = ST_IGNORED;
    if (blen < LEN_W'(LINE_LIMIT) && (tm == 2'b01 || tm == 2'b10)) begin
      if ((src.phase == PH_HEX || src.phase == PH_DONE) && src.xsum == src.expect_sum) begin
        status = (tm == 2'b01) ? ST_GGA : ST_RMC;
      end else begin
        status = ST_BAD_SUM;
      end
    end
    line_end.status = status;
    line_end.keep   = '0;
    if (status == ST_GGA) line_end.keep = pres_eff;
    else if (status == ST_RMC) line_end.keep = pres_eff & FIELD_COUNT'(1);
    for (int i = 0; i < FIELD_COUNT; i++) line_end.vals[i] = pend_eff[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= scan_t'('0);
      pre     <= scan_t'('0);
      cur_len <= '0;
      pre_len <= '0;
      cr_flag <= 1'b0;
      pres    <= '0;
      for (int i = 0; i < FIELD_COUNT; i++) pend[i] <= '0;
    end else if (take) begin
      if (is_lf) begin
        cur     <= scan_t'('0);
        cur_len <= '0;
        cr_flag <= 1'b0;
        pres    <= '0;
        for (int i = 0; i < FIELD_COUNT; i++) pend[i] <= '0;
      end else begin
        cur     <= nxt;
        cur_len <= nxt_len;
        pre     <= cur;
        pre_len <= cur_len;
        cr_flag <= (rx_byte == CH_CR);
        pres    <= pres_eff;
        for (int i = 0; i < FIELD_COUNT; i++) pend[i] <= pend_eff[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/nmea_gga_rmc_sentence_parser.sv -----
// Top level of the NMEA GGA/RMC sentence parser: handshakes, held record
// and result register. Depends on nggp_pkg and nggp_line_scan.
//
//  Channel | Direction | Handshake           | Beat payload
//  rx      | in        | rx_valid/rx_stall   | rx_byte
//  res     | out       | res_valid/res_stall | line_status and held record fields
//
// One byte is taken every cycle unless stalled; a line end gives its result next cycle.
// The held record is the result register; it changes only on a line end.
// Only an LF byte is held off, and only while an earlier result waits.
// Synchronous reset clears the scanner and zeroes the held record.
`default_nettype none
module nmea_gga_rmc_sentence_parser #(
  parameter int unsigned LINE_LIMIT = 127
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  line_status,
  output logic [24:0] utc_time,
  output logic [26:0] latitude,
  output logic [7:0]  latitude_side,
  output logic [27:0] longitude,
  output logic [7:0]  longitude_side,
  output logic [7:0]  fix_quality,
  output logic [7:0]  satellite_count,
  output logic [15:0] hdop_scaled,
  output logic signed [27:0] altitude_scaled
);
  import nggp_pkg::*;

  line_end_t        line_end;
  logic             take, take_lf;
  status_t          status;
  logic [VAL_W-1:0] held [FIELD_COUNT];

  assign rx_stall = res_valid && res_stall && (rx_byte == CH_LF);
  assign take     = rx_valid && !rx_stall;
  assign take_lf  = take && (rx_byte == CH_LF);

  nggp_line_scan #(.LINE_LIMIT(LINE_LIMIT)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rx_byte  (rx_byte),
    .line_end (line_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      status    <= ST_IGNORED;
      for (int i = 0; i < FIELD_COUNT; i++) held[i] <= '0;
    end else begin
      if (take_lf) begin
        res_valid <= 1'b1;
        status    <= line_end.status;
        for (int i = 0; i < FIELD_COUNT; i++) begin
          if (line_end.keep[i]) held[i] <= line_end.vals[i];
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign line_status     = status;
  assign utc_time        = held[0][24:0];
  assign latitude        = held[1][26:0];
  assign latitude_side   = held[2][7:0];
  assign longitude       = held[3][27:0];
  assign longitude_side  = held[4][7:0];
  assign fix_quality     = held[5][7:0];
  assign satellite_count = held[6][7:0];
  assign hdop_scaled     = held[7][15:0];
  assign altitude_scaled = signed'(held[8][27:0]);

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> res_valid) else $error("input stalled without a waiting result");

  a_lf_gives_result: assert property (@(posedge clk) disable iff (rst)
    take_lf |=> res_valid) else $error("line end gave no result");

  a_record_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> ($stable(utc_time) && $stable(altitude_scaled)
      && $stable(line_status))) else $error("record changed while result waits");

endmodule
`default_nettype wire
